### rtl/core/nupm_pkg.sv
// shared constants and controller/datapath interface types for the palette matcher
package nupm_pkg;

    localparam int MAX_LEVELS   = 16;
    localparam int MAX_ENTRIES  = MAX_LEVELS * MAX_LEVELS * MAX_LEVELS;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int LVL_W        = $clog2(MAX_LEVELS);
    localparam int CFG_W        = 5;
    localparam int LEVELS_RESET = 16;
    localparam int COORD_W      = 16;
    localparam int CHAN_W       = 8;
    localparam int SQ_W         = 2 * CHAN_W;
    localparam int DIST_W       = SQ_W + 2;

    typedef struct packed {
        logic accept;
        logic clear_en;
        logic scan_start;
        logic scan_en;
        logic commit;
    } nupm_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic out_free;
    } nupm_status_t;

endpackage

### rtl/core/nupm_ram.sv
// generic single-write, single-read ram with registered read data
module nupm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/nupm_ctrl.sv
// sequencing state machine: clear sweep, pixel intake, scan and commit
module nupm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  first_pixel,
    output logic                  in_stall,
    output nupm_pkg::nupm_cmd_t    cmd,
    input  nupm_pkg::nupm_status_t status
);

    import nupm_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_done)
                begin
                    pend_next = 1'b0;
                    if (pend_reg)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (first_pixel)
                    begin
                        pend_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

### rtl/core/nupm_dp.sv
// datapath: level register, free map, scan pipeline, winner tracking and result register
module nupm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [nupm_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic                          first_pixel,
    input  logic [nupm_pkg::COORD_W-1:0]  pos_x,
    input  logic [nupm_pkg::COORD_W-1:0]  pos_y,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_red,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_green,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_blue,
    input  nupm_pkg::nupm_cmd_t           cmd,
    output nupm_pkg::nupm_status_t        status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nupm_pkg::COORD_W-1:0]  out_x,
    output logic [nupm_pkg::COORD_W-1:0]  out_y,
    output logic [nupm_pkg::CHAN_W-1:0]   out_red,
    output logic [nupm_pkg::CHAN_W-1:0]   out_green,
    output logic [nupm_pkg::CHAN_W-1:0]   out_blue,
    output logic [nupm_pkg::DIST_W-1:0]   match_distance,
    output logic                          palette_exhausted
);

    import nupm_pkg::*;

    // configuration and latched pixel
    logic [CFG_W-1:0]   levels_reg;
    logic [CFG_W-1:0]   lv_eff;
    logic [CFG_W-1:0]   lv_m1;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [CHAN_W-1:0]  cr_reg, cg_reg, cb_reg;

    // free map
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_wdata;
    logic               ram_rdata;

    // issue stage
    logic [LVL_W-1:0]   r_reg, g_reg, b_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               issue_done_reg;
    logic               issue;
    logic               r_last, g_last, b_last;

    // stage 1: read data back from the map
    logic               v1_reg;
    logic [LVL_W-1:0]   s1_r_reg, s1_g_reg, s1_b_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [CHAN_W-1:0]  dr, dg, db;

    // stage 2: squares registered, sum and compare
    logic               v2_reg;
    logic               s2_free_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [LVL_W-1:0]   s2_r_reg, s2_g_reg, s2_b_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [DIST_W-1:0]  cand_dist;
    logic               hit;

    // winner and cutoff
    logic               found_reg;
    logic               stop_reg;
    logic [DIST_W-1:0]  win_d_reg;
    logic [IDX_W-1:0]   win_i_reg;
    logic [LVL_W-1:0]   win_r_reg, win_g_reg, win_b_reg;
    logic [DIST_W-1:0]  cutoff_reg;

    logic               out_valid_reg;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        if (int'(levels_reg) > MAX_LEVELS)
        begin
            lv_eff = CFG_W'(MAX_LEVELS);
        end
        else
        begin
            lv_eff = levels_reg;
        end
        lv_m1 = lv_eff - CFG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= CFG_W'(LEVELS_RESET);
        end
        else if (cfg_write_en)
        begin
            levels_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            cr_reg <= in_red;
            cg_reg <= in_green;
            cb_reg <= in_blue;
        end
    end

    // clear sweep marks every entry free, the commit marks the winner used
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = 1'b1;
        if (cmd.clear_en)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.commit && found_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = win_i_reg;
            ram_wdata = 1'b0;
        end
    end

    assign status.clear_done = (clr_cnt_reg == IDX_W'(MAX_ENTRIES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            if (status.clear_done)
            begin
                clr_cnt_reg <= '0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
        end
    end

    nupm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ENTRIES)
    ) u_free_map (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    // index counter walks b fastest, then g, then r
    assign issue  = cmd.scan_en && !issue_done_reg && !stop_reg;
    assign b_last = (CFG_W'(b_reg) == lv_m1);
    assign g_last = (CFG_W'(g_reg) == lv_m1);
    assign r_last = (CFG_W'(r_reg) == lv_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg          <= '0;
            g_reg          <= '0;
            b_reg          <= '0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b1;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            r_reg          <= '0;
            g_reg          <= '0;
            b_reg          <= '0;
            idx_reg        <= '0;
            issue_done_reg <= (lv_eff == '0);
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg && cmd.scan_en;
            if (issue)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (b_last)
                begin
                    b_reg <= '0;
                    if (g_last)
                    begin
                        g_reg <= '0;
                        if (r_last)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            r_reg <= r_reg + LVL_W'(1);
                        end
                    end
                    else
                    begin
                        g_reg <= g_reg + LVL_W'(1);
                    end
                end
                else
                begin
                    b_reg <= b_reg + LVL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_r_reg   <= r_reg;
        s1_g_reg   <= g_reg;
        s1_b_reg   <= b_reg;
        s1_idx_reg <= idx_reg;
    end

    always_comb
    begin
        dr = abs_diff(CHAN_W'(s1_r_reg), cr_reg);
        dg = abs_diff(CHAN_W'(s1_g_reg), cg_reg);
        db = abs_diff(CHAN_W'(s1_b_reg), cb_reg);
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg    <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg    <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg    <= SQ_W'(db) * SQ_W'(db);
        s2_free_reg <= ram_rdata;
        s2_r_reg    <= s1_r_reg;
        s2_g_reg    <= s1_g_reg;
        s2_b_reg    <= s1_b_reg;
        s2_idx_reg  <= s1_idx_reg;
    end

    assign cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    // entries still in flight behind a stopping entry are dropped
    assign hit  = v2_reg && s2_free_reg && !stop_reg && cmd.scan_en;

    assign status.scan_done = stop_reg || (issue_done_reg && !v1_reg && !v2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            found_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else if (hit)
        begin
            found_reg <= 1'b1;
            if (cand_dist < cutoff_reg)
            begin
                stop_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && (!found_reg || cand_dist < win_d_reg))
        begin
            win_d_reg <= cand_dist;
            win_i_reg <= s2_idx_reg;
            win_r_reg <= s2_r_reg;
            win_g_reg <= s2_g_reg;
            win_b_reg <= s2_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
        end
        else if (cmd.accept && first_pixel)
        begin
            cutoff_reg <= '0;
        end
        else if (cmd.commit && found_reg && (cutoff_reg <= win_d_reg))
        begin
            cutoff_reg <= win_d_reg + DIST_W'(1);
        end
    end

    // result register, a new result loads only once the previous one is taken
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_x <= px_reg;
            out_y <= py_reg;
            if (found_reg)
            begin
                out_red           <= CHAN_W'(win_r_reg);
                out_green         <= CHAN_W'(win_g_reg);
                out_blue          <= CHAN_W'(win_b_reg);
                match_distance    <= win_d_reg;
                palette_exhausted <= 1'b0;
            end
            else
            begin
                out_red           <= cr_reg;
                out_green         <= cg_reg;
                out_blue          <= cb_reg;
                match_distance    <= '0;
                palette_exhausted <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/nearest_unused_palette_match.sv
// top level of the nearest-unused palette matcher
//
// input channel: in_valid/in_stall with first_pixel, pos_x, pos_y and an rgb colour;
// a transfer happens on a rising edge with in_valid high and in_stall low.
// output channel: out_valid/out_stall with the coordinates, the chosen palette
// colour, its squared distance and the exhausted flag, one result per pixel.
// cfg_write_en/cfg_write_data set the level count L (saturated at 16); write only
// while idle.
// after reset the free map is swept to all free, with in_stall high.
// a pixel with first_pixel set starts with the same sweep.
// each pixel then scans up to L*L*L palette entries, one entry per cycle through
// the single read port of the free map, fewer when the scan stops early on an
// entry below the cutoff.
// one pixel is worked on at a time; the next is taken while the last result
// still waits in the output register. a stalled receiver holds the result
// steady and the block waits at commit until the output register is free.
module nearest_unused_palette_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [nupm_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          first_pixel,
    input  logic [nupm_pkg::COORD_W-1:0]  pos_x,
    input  logic [nupm_pkg::COORD_W-1:0]  pos_y,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_red,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_green,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_blue,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nupm_pkg::COORD_W-1:0]  out_x,
    output logic [nupm_pkg::COORD_W-1:0]  out_y,
    output logic [nupm_pkg::CHAN_W-1:0]   out_red,
    output logic [nupm_pkg::CHAN_W-1:0]   out_green,
    output logic [nupm_pkg::CHAN_W-1:0]   out_blue,
    output logic [nupm_pkg::DIST_W-1:0]   match_distance,
    output logic                          palette_exhausted
);

    import nupm_pkg::*;

    nupm_cmd_t    cmd;
    nupm_status_t status;

    nupm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .first_pixel (first_pixel),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .status      (status)
    );

    nupm_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .first_pixel       (first_pixel),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .in_red            (in_red),
        .in_green          (in_green),
        .in_blue           (in_blue),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_x             (out_x),
        .out_y             (out_y),
        .out_red           (out_red),
        .out_green         (out_green),
        .out_blue          (out_blue),
        .match_distance    (match_distance),
        .palette_exhausted (palette_exhausted)
    );

endmodule

### bench/palette_match_checker.sv
`timescale 1ns / 1ps
// result checker for the palette matcher: tracks the free map and cutoff, predicts and compares
module palette_match_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [nupm_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          first_pixel,
    input  logic [nupm_pkg::COORD_W-1:0]  pos_x,
    input  logic [nupm_pkg::COORD_W-1:0]  pos_y,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_red,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_green,
    input  logic [nupm_pkg::CHAN_W-1:0]   in_blue,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [nupm_pkg::COORD_W-1:0]  out_x,
    input  logic [nupm_pkg::COORD_W-1:0]  out_y,
    input  logic [nupm_pkg::CHAN_W-1:0]   out_red,
    input  logic [nupm_pkg::CHAN_W-1:0]   out_green,
    input  logic [nupm_pkg::CHAN_W-1:0]   out_blue,
    input  logic [nupm_pkg::DIST_W-1:0]   match_distance,
    input  logic                          palette_exhausted,
    output int                            mismatches,
    output int                            pending
);

    import nupm_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [DIST_W-1:0]  dist_sq;
        logic               exhausted;
    } pixel_match_t;

    logic [CFG_W-1:0]       levels = CFG_W'(LEVELS_RESET);
    bit [MAX_ENTRIES-1:0]   entry_free = '1;
    logic [DIST_W-1:0]      cutoff = '0;
    pixel_match_t           expected_matches[$];
    pixel_match_t           want;
    pixel_match_t           got;
    int                     fail_count = 0;
    int                     queued = 0;

    assign mismatches = fail_count;
    assign pending    = queued;

    function automatic pixel_match_t nearest_free_color(
        input logic               first,
        input logic [COORD_W-1:0] px,
        input logic [COORD_W-1:0] py,
        input logic [CHAN_W-1:0]  cr,
        input logic [CHAN_W-1:0]  cg,
        input logic [CHAN_W-1:0]  cb
    );
        int lv;
        int idx;
        int d;
        int win_d;
        int win_i;
        int r;
        int g;
        int b;
        bit found;
        bit stop;
        pixel_match_t m;
        lv = (levels > CFG_W'(MAX_LEVELS)) ? MAX_LEVELS : int'(levels);
        if (first)
        begin
            entry_free = '1;
            cutoff     = '0;
        end
        found = 0;
        stop  = 0;
        idx   = 0;
        win_d = 0;
        win_i = 0;
        m     = '0;
        m.x   = px;
        m.y   = py;
        for (r = 0; r < lv && !stop; r++)
        begin
            for (g = 0; g < lv && !stop; g++)
            begin
                for (b = 0; b < lv && !stop; b++)
                begin
                    if (entry_free[idx])
                    begin
                        d = (r - int'(cr)) * (r - int'(cr)) + (g - int'(cg)) * (g - int'(cg))
                            + (b - int'(cb)) * (b - int'(cb));
                        if (!found || d < win_d)
                        begin
                            found   = 1;
                            win_d   = d;
                            win_i   = idx;
                            m.red   = CHAN_W'(r);
                            m.green = CHAN_W'(g);
                            m.blue  = CHAN_W'(b);
                        end
                        // first free entry under the cutoff ends the scan
                        if (d < int'(cutoff))
                            stop = 1;
                    end
                    idx++;
                end
            end
        end
        if (found)
        begin
            entry_free[win_i] = 0;
            if (int'(cutoff) <= win_d)
                cutoff = DIST_W'(win_d + 1);
            m.dist_sq   = DIST_W'(win_d);
            m.exhausted = 0;
        end
        else
        begin
            m.red       = cr;
            m.green     = cg;
            m.blue      = cb;
            m.dist_sq   = '0;
            m.exhausted = 1;
        end
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels     = CFG_W'(LEVELS_RESET);
            entry_free = '1;
            cutoff     = '0;
            expected_matches.delete();
            queued     = 0;
        end
        else
        begin
            if (cfg_write_en)
                levels = cfg_write_data;
            if (out_valid && !out_stall)
            begin
                got = '{out_x, out_y, out_red, out_green, out_blue, match_distance,
                        palette_exhausted};
                if (expected_matches.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result x=%h y=%h rgb=%h/%h/%h dist=%0d exh=%b",
                                 $realtime, got.x, got.y, got.red, got.green, got.blue,
                                 got.dist_sq, got.exhausted);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch exp x=%h y=%h rgb=%h/%h/%h dist=%0d exh=%b",
                                      " got x=%h y=%h rgb=%h/%h/%h dist=%0d exh=%b"},
                                     $realtime, want.x, want.y, want.red, want.green, want.blue,
                                     want.dist_sq, want.exhausted, got.x, got.y, got.red,
                                     got.green, got.blue, got.dist_sq, got.exhausted);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_matches.push_back(nearest_free_color(first_pixel, pos_x, pos_y,
                                                              in_red, in_green, in_blue));
            queued = expected_matches.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// top of the palette matcher bench: clock, reset, pixel stimulus, pacing and verdict
module testbench;

    import nupm_pkg::*;

    typedef enum int {
        PACE_NONE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_t;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_write_en = 0;
    logic [CFG_W-1:0]      cfg_write_data = '0;
    logic                  in_valid = 0;
    logic                  in_stall;
    logic                  first_pixel = 0;
    logic [COORD_W-1:0]    pos_x = '0;
    logic [COORD_W-1:0]    pos_y = '0;
    logic [CHAN_W-1:0]     in_red = '0;
    logic [CHAN_W-1:0]     in_green = '0;
    logic [CHAN_W-1:0]     in_blue = '0;
    logic                  out_valid;
    logic                  out_stall = 0;
    logic [COORD_W-1:0]    out_x;
    logic [COORD_W-1:0]    out_y;
    logic [CHAN_W-1:0]     out_red;
    logic [CHAN_W-1:0]     out_green;
    logic [CHAN_W-1:0]     out_blue;
    logic [DIST_W-1:0]     match_distance;
    logic                  palette_exhausted;
    int                    mismatches;
    int                    pending;
    pace_t                 pace = PACE_NONE;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    nearest_unused_palette_match DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .first_pixel       (first_pixel),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .in_red            (in_red),
        .in_green          (in_green),
        .in_blue           (in_blue),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_x             (out_x),
        .out_y             (out_y),
        .out_red           (out_red),
        .out_green         (out_green),
        .out_blue          (out_blue),
        .match_distance    (match_distance),
        .palette_exhausted (palette_exhausted)
    );

    palette_match_checker match_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .first_pixel       (first_pixel),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .in_red            (in_red),
        .in_green          (in_green),
        .in_blue           (in_blue),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_x             (out_x),
        .out_y             (out_y),
        .out_red           (out_red),
        .out_green         (out_green),
        .out_blue          (out_blue),
        .match_distance    (match_distance),
        .palette_exhausted (palette_exhausted),
        .mismatches        (mismatches),
        .pending           (pending)
    );

    always @(negedge clk)
        out_stall <= (pace == PACE_RECEIVER && $urandom_range(99) < 67)
                     || (pace == PACE_BOTH && $urandom_range(99) < 10);

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_pixel(
        input logic               first,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [CHAN_W-1:0]  r,
        input logic [CHAN_W-1:0]  g,
        input logic [CHAN_W-1:0]  b
    );
        while ((pace == PACE_SENDER && $urandom_range(99) < 67)
               || (pace == PACE_BOTH && $urandom_range(99) < 10))
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid    <= 1;
        first_pixel <= first;
        pos_x       <= x;
        pos_y       <= y;
        in_red      <= r;
        in_green    <= g;
        in_blue     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain every outstanding result, then let the pipeline settle
    task automatic settle();
        in_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_levels(input logic [CFG_W-1:0] value);
        cfg_write_en   <= 1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 0;
    endtask

    initial
    begin
        int sent;
        int phase;
        int count;
        int roll;
        logic [CFG_W-1:0] lv;
        logic first;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        // reset sweep of the free map holds off the first transfer
        @(negedge clk);
        while (in_stall)
            @(negedge clk);

        // default level count of 16 straight after reset
        send_pixel(1, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0);
        send_pixel(0, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(0, 16'h5555, 16'hAAAA, 8'd0, 8'd0, 8'd0);
        send_pixel(0, 16'hAAAA, 16'h5555, 8'd8, 8'd8, 8'd8);
        send_pixel(0, 16'h00FF, 16'hFF00, 8'd15, 8'd0, 8'd15);

        // single entry palette runs out on the second pixel
        settle();
        write_levels(5'd1);
        send_pixel(1, 16'd1, 16'd2, 8'd7, 8'd7, 8'd7);
        send_pixel(0, 16'd3, 16'd4, 8'd200, 8'd100, 8'd50);
        send_pixel(0, 16'd5, 16'd6, 8'd0, 8'd0, 8'd0);

        // empty palette
        settle();
        write_levels(5'd0);
        send_pixel(1, 16'd7, 16'd8, 8'd1, 8'd2, 8'd3);
        send_pixel(0, 16'hFF00, 16'h00FF, 8'd255, 8'd128, 8'd1);

        // out-of-range level count saturates
        settle();
        write_levels(5'd31);
        send_pixel(1, 16'h1234, 16'h4321, 8'd128, 8'd64, 8'd200);
        send_pixel(0, 16'h8000, 16'h0001, 8'd3, 8'd3, 8'd3);

        settle();
        write_levels(5'd2);
        send_pixel(1, 16'd10, 16'd11, 8'd1, 8'd1, 8'd1);
        send_pixel(0, 16'd12, 16'd13, 8'd1, 8'd1, 8'd1);
        send_pixel(0, 16'd14, 16'd15, 8'd0, 8'd1, 8'd0);
        send_pixel(0, 16'd16, 16'd17, 8'd255, 8'd0, 8'd0);

        // new level count over a free map that was not cleared
        settle();
        write_levels(5'd3);
        send_pixel(0, 16'd18, 16'd19, 8'd1, 8'd1, 8'd1);
        send_pixel(0, 16'd20, 16'd21, 8'd2, 8'd0, 8'd2);

        settle();
        write_levels(5'd17);
        send_pixel(1, 16'hFFFE, 16'h0002, 8'd15, 8'd15, 8'd15);
        send_pixel(0, 16'h7FFF, 16'h8000, 8'd127, 8'd128, 8'd16);

        sent  = 0;
        phase = 0;
        while (sent < 120)
        begin
            settle();
            pace = pace_t'(phase % 4);
            roll = $urandom_range(99);
            if (roll < 8)
                lv = 5'd16;
            else if (roll < 12)
                lv = 5'd0;
            else if (roll < 16)
                lv = 5'd1;
            else if (roll < 22)
                lv = CFG_W'($urandom_range(17, 31));
            else
                lv = CFG_W'($urandom_range(2, 8));
            write_levels(lv);
            count = $urandom_range(8, 20);
            for (int k = 0; k < count; k++)
            begin
                // a phase normally opens with a cleared map, now and then it keeps the old one
                first = (k == 0) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 4);
                if ($urandom_range(99) < 60)
                begin
                    r = CHAN_W'($urandom_range(0, 17));
                    g = CHAN_W'($urandom_range(0, 17));
                    b = CHAN_W'($urandom_range(0, 17));
                end
                else
                begin
                    r = CHAN_W'($urandom_range(0, 255));
                    g = CHAN_W'($urandom_range(0, 255));
                    b = CHAN_W'($urandom_range(0, 255));
                end
                send_pixel(first, COORD_W'($urandom), COORD_W'($urandom), r, g, b);
            end
            sent += count;
            phase++;
        end

        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
